[rtl/twhsr_pkg.sv]
// shared types and constants for the two-wire humidity sensor reader
// no dependencies; used by twhsr_csr, twhsr_seq and the top level
`default_nettype none

package twhsr_pkg;

   // one time slot of input: start request, mode and sampled DATA pin
   typedef struct packed {
      logic       start_req;
      logic [1:0] mode;
      logic       data_pin;
   } req_type;

   // one time slot of output: bus levels, status and the last measurement word
   typedef struct packed {
      logic        sck;
      logic        data_level;
      logic        data_drive;
      logic        busy_res;
      logic        done_res;
      logic        error;
      logic [15:0] value;
   } rsp_type;

   // configuration registers as seen by the sequencer
   typedef struct packed {
      logic [7:0]  temp_command;
      logic [7:0]  humidity_command;
      logic [15:0] wait_slots;
   } cfg_type;

   // register indexes of the configuration port
   localparam logic [1:0] CSR_TEMP_COMMAND     = 2'd0;
   localparam logic [1:0] CSR_HUMIDITY_COMMAND = 2'd1;
   localparam logic [1:0] CSR_WAIT_SLOTS       = 2'd2;

   localparam logic [7:0]  TEMP_COMMAND_RESET     = 8'd3;
   localparam logic [7:0]  HUMIDITY_COMMAND_RESET = 8'd5;
   localparam logic [15:0] WAIT_SLOTS_RESET       = 16'd320;

   // measurement modes
   localparam logic [1:0] MODE_TEMP     = 2'd0;
   localparam logic [1:0] MODE_HUMIDITY = 2'd1;

   // transmission-start pattern, bit n is the level in slot n
   localparam logic [7:0] START_SCK = 8'b0011_0110;
   localparam logic [7:0] START_DAT = 8'b0010_0011;
   localparam logic [2:0] START_LAST_SLOT = 3'd5;

   // three-slot bit and acknowledge cells
   localparam logic [2:0] CELL_HIGH_SLOT = 3'd1;
   localparam logic [2:0] CELL_LAST_SLOT = 3'd2;
   localparam logic [2:0] LAST_BIT       = 3'd7;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_START = 4'd1,
      PH_WBIT  = 4'd2,
      PH_WACK  = 4'd3,
      PH_WAIT  = 4'd4,
      PH_RHI   = 4'd5,
      PH_AHI   = 4'd6,
      PH_RLO   = 4'd7,
      PH_ALO   = 4'd8
   } phase_type;

endpackage

`default_nettype wire

[rtl/twhsr_csr.sv]
// configuration registers: command bytes and data-ready wait length
// depends on twhsr_pkg
`default_nettype none

module twhsr_csr (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [1:0]          csr_index,
   input  wire logic [15:0]         csr_wdata,
   output      twhsr_pkg::cfg_type  cfg
);

   twhsr_pkg::cfg_type cfg_ff, cfg_in;
   logic               write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid & csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         unique case (csr_index)
            twhsr_pkg::CSR_TEMP_COMMAND:     cfg_in.temp_command     = csr_wdata[7:0];
            twhsr_pkg::CSR_HUMIDITY_COMMAND: cfg_in.humidity_command = csr_wdata[7:0];
            twhsr_pkg::CSR_WAIT_SLOTS:       cfg_in.wait_slots       = csr_wdata;
            default: ;  // unused index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_command     <= twhsr_pkg::TEMP_COMMAND_RESET;
         cfg_ff.humidity_command <= twhsr_pkg::HUMIDITY_COMMAND_RESET;
         cfg_ff.wait_slots       <= twhsr_pkg::WAIT_SLOTS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/twhsr_seq.sv]
// bus sequencer: one step of the start / command / wait / read sequence per slot
// depends on twhsr_pkg
`default_nettype none

module twhsr_seq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire twhsr_pkg::req_type  req,
   input  wire twhsr_pkg::cfg_type  cfg,
   output      twhsr_pkg::rsp_type  rsp
);

   twhsr_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic [2:0]  bit_ff, bit_in;
   logic [2:0]  slot_ff, slot_in, cur_slot;
   logic [7:0]  shift_ff, shift_in, cur_shift;
   logic [7:0]  high_ff, high_in;
   logic [15:0] wait_ff, wait_in, wait_inc;
   logic [15:0] word_ff, word_in;
   logic        cmd_ff, cmd_in, cur_cmd;
   logic        launch;

   // a start in idle runs the first start slot in the same step
   assign launch    = (phase_ff == twhsr_pkg::PH_IDLE) && req.start_req;
   assign cur_phase = launch ? twhsr_pkg::PH_START : phase_ff;
   assign cur_slot  = launch ? 3'd0 : slot_ff;
   assign cur_cmd   = launch ? (req.mode == twhsr_pkg::MODE_TEMP ||
                                req.mode == twhsr_pkg::MODE_HUMIDITY) : cmd_ff;
   assign wait_inc  = wait_ff + 16'd1;

   always_comb begin
      if (!launch)
         cur_shift = shift_ff;
      else if (req.mode == twhsr_pkg::MODE_TEMP)
         cur_shift = cfg.temp_command;
      else if (req.mode == twhsr_pkg::MODE_HUMIDITY)
         cur_shift = cfg.humidity_command;
      else
         cur_shift = 8'd0;
   end

   // next state
   always_comb begin
      phase_in = cur_phase;
      bit_in   = bit_ff;
      slot_in  = cur_slot;
      shift_in = cur_shift;
      high_in  = high_ff;
      wait_in  = wait_ff;
      word_in  = word_ff;
      cmd_in   = cur_cmd;
      unique case (cur_phase)
         twhsr_pkg::PH_IDLE: ;
         twhsr_pkg::PH_START: begin
            slot_in = cur_slot + 3'd1;
            if (cur_slot == twhsr_pkg::START_LAST_SLOT) begin
               slot_in = 3'd0;
               if (cur_cmd) begin
                  phase_in = twhsr_pkg::PH_WBIT;
                  bit_in   = 3'd0;
               end else begin
                  wait_in = 16'd0;
                  if (cfg.wait_slots == 16'd0) begin
                     phase_in = twhsr_pkg::PH_RHI;
                     bit_in   = 3'd0;
                     shift_in = 8'd0;
                  end else begin
                     phase_in = twhsr_pkg::PH_WAIT;
                  end
               end
            end
         end
         twhsr_pkg::PH_WBIT: begin
            slot_in = cur_slot + 3'd1;
            if (cur_slot == twhsr_pkg::CELL_LAST_SLOT) begin
               slot_in = 3'd0;
               if (bit_ff == twhsr_pkg::LAST_BIT) phase_in = twhsr_pkg::PH_WACK;
               else                               bit_in   = bit_ff + 3'd1;
            end
         end
         twhsr_pkg::PH_WACK: begin
            if (req.data_pin) begin
               phase_in = twhsr_pkg::PH_IDLE;
            end else begin
               wait_in = 16'd0;
               if (cfg.wait_slots == 16'd0) begin
                  phase_in = twhsr_pkg::PH_RHI;
                  bit_in   = 3'd0;
                  slot_in  = 3'd0;
                  shift_in = 8'd0;
               end else begin
                  phase_in = twhsr_pkg::PH_WAIT;
               end
            end
         end
         twhsr_pkg::PH_WAIT: begin
            wait_in = wait_inc;
            if (wait_inc >= cfg.wait_slots) begin
               phase_in = twhsr_pkg::PH_RHI;
               bit_in   = 3'd0;
               slot_in  = 3'd0;
               shift_in = 8'd0;
            end
         end
         twhsr_pkg::PH_RHI, twhsr_pkg::PH_RLO: begin
            if (cur_slot == 3'd0) begin
               // data-ready check on the first low slot of the high byte
               if (cur_phase == twhsr_pkg::PH_RHI && bit_ff == 3'd0 && req.data_pin)
                  phase_in = twhsr_pkg::PH_IDLE;
               else
                  slot_in = 3'd1;
            end else begin
               shift_in = {cur_shift[6:0], req.data_pin};
               slot_in  = 3'd0;
               if (bit_ff == twhsr_pkg::LAST_BIT)
                  phase_in = (cur_phase == twhsr_pkg::PH_RHI) ? twhsr_pkg::PH_AHI
                                                               : twhsr_pkg::PH_ALO;
               else
                  bit_in = bit_ff + 3'd1;
            end
         end
         twhsr_pkg::PH_AHI, twhsr_pkg::PH_ALO: begin
            slot_in = cur_slot + 3'd1;
            if (cur_slot == twhsr_pkg::CELL_LAST_SLOT) begin
               slot_in = 3'd0;
               if (cur_phase == twhsr_pkg::PH_AHI) begin
                  high_in  = cur_shift;
                  phase_in = twhsr_pkg::PH_RLO;
                  bit_in   = 3'd0;
                  shift_in = 8'd0;
               end else begin
                  word_in  = {high_ff, cur_shift};
                  phase_in = twhsr_pkg::PH_IDLE;
               end
            end
         end
         default: phase_in = twhsr_pkg::PH_IDLE;
      endcase
   end

   // slot outputs
   always_comb begin
      rsp            = '0;
      rsp.busy_res   = 1'b1;
      rsp.value      = word_in;
      unique case (cur_phase)
         twhsr_pkg::PH_IDLE: rsp.busy_res = 1'b0;
         twhsr_pkg::PH_START: begin
            rsp.sck        = twhsr_pkg::START_SCK[cur_slot];
            rsp.data_level = twhsr_pkg::START_DAT[cur_slot];
            rsp.data_drive = 1'b1;
         end
         twhsr_pkg::PH_WBIT: begin
            rsp.data_level = cur_shift[3'd7 - bit_ff];
            rsp.data_drive = 1'b1;
            rsp.sck        = (cur_slot == twhsr_pkg::CELL_HIGH_SLOT);
         end
         twhsr_pkg::PH_WACK: begin
            // missing acknowledge from the sensor
            rsp.sck      = 1'b1;
            rsp.done_res = req.data_pin;
            rsp.error    = req.data_pin;
         end
         twhsr_pkg::PH_WAIT: ;
         twhsr_pkg::PH_RHI, twhsr_pkg::PH_RLO: begin
            if (cur_slot == 3'd0) begin
               // data not ready: timeout
               if (cur_phase == twhsr_pkg::PH_RHI && bit_ff == 3'd0 && req.data_pin) begin
                  rsp.done_res = 1'b1;
                  rsp.error    = 1'b1;
               end
            end else begin
               rsp.sck = 1'b1;
            end
         end
         twhsr_pkg::PH_AHI, twhsr_pkg::PH_ALO: begin
            rsp.data_drive = 1'b1;
            rsp.sck        = (cur_slot == twhsr_pkg::CELL_HIGH_SLOT);
            rsp.done_res   = (cur_phase == twhsr_pkg::PH_ALO) &&
                             (cur_slot == twhsr_pkg::CELL_LAST_SLOT);
         end
         default: rsp.busy_res = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= twhsr_pkg::PH_IDLE;
         bit_ff   <= 3'd0;
         slot_ff  <= 3'd0;
         shift_ff <= 8'd0;
         high_ff  <= 8'd0;
         wait_ff  <= 16'd0;
         word_ff  <= 16'd0;
         cmd_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         slot_ff  <= slot_in;
         shift_ff <= shift_in;
         high_ff  <= high_in;
         wait_ff  <= wait_in;
         word_ff  <= word_in;
         cmd_ff   <= cmd_in;
      end
   end

endmodule

`default_nettype wire

[rtl/two_wire_humidity_sensor_reader_unit.sv]
// two-wire humidity sensor reader: top level with input and result registers
// depends on twhsr_pkg, twhsr_csr and twhsr_seq
// throughput: one slot per cycle unless the result stage stalls, set by the single-step
//   sequencer between the two registers
// a slot is taken while the previous result still waits; only a stalled full result stage
//   holds the input stage
// reset (synchronous, active high): sequencer idle, counters and word cleared,
//   registers to their defaults (commands 3 and 5, wait 320 slots), both stages empty
`default_nettype none

module two_wire_humidity_sensor_reader_unit (
   input  wire logic                clock,
   input  wire logic                reset,
   // slot input channel
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire twhsr_pkg::req_type  req_data,
   // slot result channel
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      twhsr_pkg::rsp_type  rsp_data,
   // configuration write channel
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [1:0]          csr_index,
   input  wire logic [15:0]         csr_wdata
);

   twhsr_pkg::req_type req_ff;
   twhsr_pkg::rsp_type rsp_ff, step_rsp;
   twhsr_pkg::cfg_type cfg;
   logic               req_vld_ff, req_vld_in;
   logic               rsp_vld_ff, rsp_vld_in;
   logic               req_take;   // input transfer
   logic               advance;    // held slot moves through the sequencer

   // a held slot advances when the result stage is empty or being drained
   assign advance    = req_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall  = req_vld_ff && !advance;
   assign req_take   = req_valid && !req_stall;
   assign req_vld_in = req_take || (req_vld_ff && !advance);
   assign rsp_vld_in = advance || (rsp_vld_ff && rsp_stall);

   twhsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer state moves exactly once per slot
   twhsr_seq u_seq (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (req_ff),
      .cfg   (cfg),
      .rsp   (step_rsp)
   );

   // handshake control
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload stages, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) req_ff <= req_data;
      if (advance)  rsp_ff <= step_rsp;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // a new result only appears after a held slot was present
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(req_vld_ff))
      else $error("result appeared without a held slot");

   // the input stage only stalls behind a full, stalled result stage
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_vld_ff && rsp_stall && req_vld_ff))
      else $error("input stalled without a blocked result");

   // error is only flagged on the final slot of a sequence
   a_err_done: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (!rsp_ff.error || (rsp_ff.done_res && rsp_ff.busy_res)))
      else $error("error without done");

   // an idle slot neither clocks nor drives the bus
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_ff.busy_res) |-> (!rsp_ff.sck && !rsp_ff.data_drive))
      else $error("bus activity outside a sequence");

endmodule

`default_nettype wire

[dv/tb_two_wire_humidity_sensor_reader_unit.sv]
// self-checking testbench for two_wire_humidity_sensor_reader_unit: drives time slots, writes
// the command and wait registers, and checks every slot result against a slot-accurate model
// depends on twhsr_pkg and the rtl top level
`timescale 1ns / 100ps

module tb_two_wire_humidity_sensor_reader_unit;

   localparam int CYCLE_LIMIT = 600000;
   localparam int ITEM_COUNT  = 1750;

   // mode and register codes the package does not name
   localparam logic [1:0] MODE_NO_COMMAND = 2'd2;
   localparam logic [1:0] MODE_SPARE      = 2'd3;
   localparam logic [1:0] CSR_SPARE       = 2'd3;

   // transmission-start pattern, bit n is the level in slot n
   localparam logic [5:0] START_CLOCK = 6'b110110;
   localparam logic [5:0] START_LINE  = 6'b100011;

   // how the sensor side answers during one measurement
   typedef enum {RUN_CLEAN, RUN_NO_ACK, RUN_NOT_READY, RUN_NOISE} run_kind_type;
   // what the sensor shifts back in the two data bytes
   typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_type;

   // slot-accurate model of the bus sequencer plus the queue of slot results still owed
   class sensor_bus_board;
      logic [7:0]  temp_cmd = 8'd3;
      logic [7:0]  hum_cmd  = 8'd5;
      logic [15:0] wait_len = 16'd320;

      twhsr_pkg::phase_type phase = twhsr_pkg::PH_IDLE;
      logic [2:0]  bit_n   = '0;
      logic [2:0]  slot_n  = '0;
      logic [7:0]  shifter = '0;
      logic [7:0]  hi_byte = '0;
      logic [15:0] wait_n  = '0;
      logic [15:0] word    = '0;
      bit          cmd_due = 1'b0;

      twhsr_pkg::rsp_type slots_due[$];
      int errors, slots_taken, words_done, ack_fails, timeouts, reg_writes;

      function void set_register(logic [1:0] idx, logic [15:0] val);
         reg_writes++;
         case (idx)
            twhsr_pkg::CSR_TEMP_COMMAND:     temp_cmd = val[7:0];
            twhsr_pkg::CSR_HUMIDITY_COMMAND: hum_cmd  = val[7:0];
            twhsr_pkg::CSR_WAIT_SLOTS:       wait_len = val;
            default: ;  // unused index leaves every register alone
         endcase
      endfunction

      function void open_read(twhsr_pkg::phase_type ph);
         phase   = ph;
         bit_n   = '0;
         slot_n  = '0;
         shifter = '0;
      endfunction

      function void open_wait();
         wait_n = '0;
         if (wait_len == 16'd0) open_read(twhsr_pkg::PH_RHI);
         else phase = twhsr_pkg::PH_WAIT;
      endfunction

      // advance the sequencer by one slot and return the bus levels it shows
      function twhsr_pkg::rsp_type predict_slot(twhsr_pkg::req_type r);
         twhsr_pkg::rsp_type o;
         o = '0;
         o.busy_res = 1'b1;
         if (phase == twhsr_pkg::PH_IDLE) begin
            if (r.start_req) begin
               cmd_due = (r.mode == twhsr_pkg::MODE_TEMP) ||
                         (r.mode == twhsr_pkg::MODE_HUMIDITY);
               shifter = (r.mode == twhsr_pkg::MODE_TEMP) ? temp_cmd :
                         (r.mode == twhsr_pkg::MODE_HUMIDITY) ? hum_cmd : 8'd0;
               phase   = twhsr_pkg::PH_START;
               slot_n  = '0;
            end else begin
               o.busy_res = 1'b0;
            end
         end
         case (phase)
            twhsr_pkg::PH_START: begin
               o.sck        = START_CLOCK[slot_n];
               o.data_level = START_LINE[slot_n];
               o.data_drive = 1'b1;
               slot_n++;
               if (slot_n >= 3'd6) begin
                  slot_n = '0;
                  if (cmd_due) begin
                     phase = twhsr_pkg::PH_WBIT;
                     bit_n = '0;
                  end else begin
                     open_wait();
                  end
               end
            end
            twhsr_pkg::PH_WBIT: begin
               o.data_level = shifter[7 - bit_n];
               o.data_drive = 1'b1;
               o.sck        = (slot_n == 3'd1);
               slot_n++;
               if (slot_n >= 3'd3) begin
                  slot_n = '0;
                  if (bit_n >= 3'd7) phase = twhsr_pkg::PH_WACK;
                  else bit_n++;
               end
            end
            twhsr_pkg::PH_WACK: begin
               o.sck = 1'b1;
               if (r.data_pin) begin
                  o.done_res = 1'b1;
                  o.error    = 1'b1;
                  phase      = twhsr_pkg::PH_IDLE;
                  ack_fails++;
               end else begin
                  open_wait();
               end
            end
            twhsr_pkg::PH_WAIT: begin
               wait_n++;
               if (wait_n >= wait_len) open_read(twhsr_pkg::PH_RHI);
            end
            twhsr_pkg::PH_RHI, twhsr_pkg::PH_RLO: begin
               if (slot_n == 3'd0) begin
                  // first low slot of the high byte doubles as the data-ready check
                  if (phase == twhsr_pkg::PH_RHI && bit_n == 3'd0 && r.data_pin) begin
                     o.done_res = 1'b1;
                     o.error    = 1'b1;
                     phase      = twhsr_pkg::PH_IDLE;
                     timeouts++;
                  end else begin
                     slot_n = 3'd1;
                  end
               end else begin
                  o.sck   = 1'b1;
                  shifter = {shifter[6:0], r.data_pin};
                  slot_n  = '0;
                  if (bit_n >= 3'd7)
                     phase = (phase == twhsr_pkg::PH_RHI) ? twhsr_pkg::PH_AHI
                                                          : twhsr_pkg::PH_ALO;
                  else bit_n++;
               end
            end
            twhsr_pkg::PH_AHI, twhsr_pkg::PH_ALO: begin
               o.data_drive = 1'b1;
               o.sck        = (slot_n == 3'd1);
               slot_n++;
               if (slot_n >= 3'd3) begin
                  slot_n = '0;
                  if (phase == twhsr_pkg::PH_AHI) begin
                     hi_byte = shifter;
                     open_read(twhsr_pkg::PH_RLO);
                  end else begin
                     word       = {hi_byte, shifter};
                     o.done_res = 1'b1;
                     phase      = twhsr_pkg::PH_IDLE;
                     words_done++;
                  end
               end
            end
            default: ;
         endcase
         o.value = word;
         return o;
      endfunction

      function void take_slot(twhsr_pkg::req_type r);
         slots_taken++;
         slots_due.push_back(predict_slot(r));
      endfunction

      function void match(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s expected %0h got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_slot(twhsr_pkg::rsp_type got);
         twhsr_pkg::rsp_type want;
         if (slots_due.size() == 0) begin
            $error("result transfer with no slot pending: %0h", got);
            errors++;
            return;
         end
         want = slots_due.pop_front();
         match("sck", want.sck, got.sck);
         match("data_level", want.data_level, got.data_level);
         match("data_drive", want.data_drive, got.data_drive);
         match("busy_res", want.busy_res, got.busy_res);
         match("done_res", want.done_res, got.done_res);
         match("error", want.error, got.error);
         match("value", want.value, got.value);
      endfunction
   endclass

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // dut ports; the driven inputs are known from time zero
   logic                req_valid = 1'b0;
   logic                req_stall;
   twhsr_pkg::req_type  req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   twhsr_pkg::rsp_type  rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   two_wire_humidity_sensor_reader_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sensor_bus_board sb = new;

   // plan for the next measurement started on purpose by the directed part
   bit            start_now  = 1'b0;
   logic [1:0]    plan_mode  = twhsr_pkg::MODE_TEMP;
   run_kind_type  plan_kind  = RUN_CLEAN;
   fill_type      plan_fill  = FILL_RANDOM;
   // how the sensor answers in the measurement now running
   run_kind_type  run_kind   = RUN_CLEAN;
   fill_type      run_fill   = FILL_RANDOM;

   int cycles = 0;
   int stall_left = 0;
   int stall_style = 0;

   // cycle budget: any hang ends the run here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_two_wire_humidity_sensor_reader_unit failed");
         $finish;
      end
   end

   // result side: check each transfer, stall in windows of changing style
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_slot(rsp_data);
      if (stall_left == 0) begin
         stall_style <= $urandom_range(0, 3);
         stall_left  <= $urandom_range(40, 300);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_style)
         0: rsp_stall <= 1'b0;                          // free running
         1: rsp_stall <= ($urandom_range(0, 3) == 0);   // light back-pressure
         2: rsp_stall <= ($urandom_range(0, 3) != 0);   // heavy back-pressure
         default: rsp_stall <= ~rsp_stall;              // alternating on and off
      endcase
   end

   // choose the next slot from where the sequencer stands; the sensor side only
   // matters at the acknowledge, the data-ready check and the sampled read slots
   function automatic twhsr_pkg::req_type next_slot();
      twhsr_pkg::req_type r;
      r.start_req = 1'($urandom_range(0, 1));  // ignored while busy
      r.mode      = 2'($urandom_range(0, 3));
      r.data_pin  = 1'($urandom_range(0, 1));
      if (sb.phase == twhsr_pkg::PH_IDLE) begin
         r.start_req = start_now || ($urandom_range(0, 5) == 0);
         if (r.start_req) begin
            if (start_now) begin
               r.mode    = plan_mode;
               run_kind  = plan_kind;
               run_fill  = plan_fill;
               start_now = 1'b0;
            end else begin
               case ($urandom_range(0, 9))
                  0: run_kind = RUN_NO_ACK;
                  1: run_kind = RUN_NOT_READY;
                  2: run_kind = RUN_NOISE;
                  default: run_kind = RUN_CLEAN;
               endcase
               case ($urandom_range(0, 7))
                  0: run_fill = FILL_ONES;
                  1: run_fill = FILL_ZEROS;
                  default: run_fill = FILL_RANDOM;
               endcase
            end
         end
      end else if (sb.phase == twhsr_pkg::PH_WACK) begin
         if (run_kind != RUN_NOISE) r.data_pin = (run_kind == RUN_NO_ACK);
      end else if (sb.phase == twhsr_pkg::PH_RHI || sb.phase == twhsr_pkg::PH_RLO) begin
         if (sb.slot_n == 3'd0) begin
            if (sb.phase == twhsr_pkg::PH_RHI && sb.bit_n == 3'd0 && run_kind != RUN_NOISE)
               r.data_pin = (run_kind == RUN_NOT_READY);
         end else if (run_fill != FILL_RANDOM) begin
            r.data_pin = (run_fill == FILL_ONES);
         end
      end
      return r;
   endfunction

   // send slots in bursts with random gaps; either a count, or one whole measurement
   task automatic stream(input int n_items, input bit one_run);
      twhsr_pkg::req_type item;
      int      sent;
      int      burst;
      int      gap;
      bit      began;
      sent  = 0;
      burst = $urandom_range(1, 48);
      began = (sb.phase != twhsr_pkg::PH_IDLE);
      while (one_run ? !(began && sb.phase == twhsr_pkg::PH_IDLE) : (sent < n_items)) begin
         if (burst == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst = $urandom_range(1, 48);
         end
         item = next_slot();
         if (sb.phase == twhsr_pkg::PH_IDLE && item.start_req) began = 1'b1;
         req_valid <= 1'b1;
         req_data  <= item;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         sb.take_slot(item);
         sent++;
         burst--;
      end
   endtask

   // hold the sender until every owed result has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.slots_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(idx, val);
      csr_valid <= 1'b0;
   endtask

   task automatic measure(input logic [1:0] m, input run_kind_type k, input fill_type f);
      plan_mode = m;
      plan_kind = k;
      plan_fill = f;
      start_now = 1'b1;
      stream(0, 1'b1);
   endtask

   initial begin
      int n;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset commands and the full 320-slot wait, all-ones word
      measure(twhsr_pkg::MODE_TEMP, RUN_CLEAN, FILL_ONES);
      settle();

      // extreme commands, no wait at all
      write_csr(twhsr_pkg::CSR_TEMP_COMMAND, 16'h00FF);
      write_csr(twhsr_pkg::CSR_HUMIDITY_COMMAND, 16'h0000);
      write_csr(twhsr_pkg::CSR_WAIT_SLOTS, 16'd0);
      measure(twhsr_pkg::MODE_TEMP, RUN_CLEAN, FILL_ZEROS);
      measure(twhsr_pkg::MODE_HUMIDITY, RUN_CLEAN, FILL_ONES);
      measure(MODE_NO_COMMAND, RUN_CLEAN, FILL_RANDOM);
      measure(MODE_SPARE, RUN_CLEAN, FILL_RANDOM);
      // missing acknowledge and data never ready: the word must hold
      measure(twhsr_pkg::MODE_TEMP, RUN_NO_ACK, FILL_RANDOM);
      measure(twhsr_pkg::MODE_HUMIDITY, RUN_NOT_READY, FILL_RANDOM);
      measure(MODE_NO_COMMAND, RUN_NOT_READY, FILL_RANDOM);
      settle();

      // unused register index must change nothing
      write_csr(CSR_SPARE, 16'hFFFF);
      measure(twhsr_pkg::MODE_HUMIDITY, RUN_CLEAN, FILL_RANDOM);
      settle();

      // longest wait, set only for sequences that abort before it
      write_csr(twhsr_pkg::CSR_WAIT_SLOTS, 16'hFFFF);
      write_csr(twhsr_pkg::CSR_TEMP_COMMAND, 16'h0000);
      write_csr(twhsr_pkg::CSR_HUMIDITY_COMMAND, 16'h00FF);
      measure(twhsr_pkg::MODE_TEMP, RUN_NO_ACK, FILL_RANDOM);
      measure(twhsr_pkg::MODE_HUMIDITY, RUN_NO_ACK, FILL_RANDOM);
      settle();

      // shorten the wait while the sequencer is ten slots into it
      write_csr(twhsr_pkg::CSR_WAIT_SLOTS, 16'd40);
      write_csr(twhsr_pkg::CSR_TEMP_COMMAND, 16'h00A5);
      plan_mode = twhsr_pkg::MODE_TEMP;
      plan_kind = RUN_CLEAN;
      plan_fill = FILL_RANDOM;
      start_now = 1'b1;
      stream(41, 1'b0);
      settle();
      write_csr(twhsr_pkg::CSR_WAIT_SLOTS, 16'd4);
      stream(0, 1'b1);
      settle();

      // random part: new register settings between stretches of slots
      while (sb.slots_taken < ITEM_COUNT) begin
         settle();
         write_csr(twhsr_pkg::CSR_TEMP_COMMAND, ($urandom_range(0, 3) == 0) ?
                   16'($urandom_range(0, 1) * 255) : 16'($urandom_range(0, 255)));
         write_csr(twhsr_pkg::CSR_HUMIDITY_COMMAND, ($urandom_range(0, 3) == 0) ?
                   16'($urandom_range(0, 1) * 255) : 16'($urandom_range(0, 255)));
         case ($urandom_range(0, 5))
            0: write_csr(twhsr_pkg::CSR_WAIT_SLOTS, 16'd0);
            1: write_csr(twhsr_pkg::CSR_WAIT_SLOTS, 16'd1);
            default: write_csr(twhsr_pkg::CSR_WAIT_SLOTS, 16'($urandom_range(2, 24)));
         endcase
         n = $urandom_range(120, 260);
         if (n > ITEM_COUNT - sb.slots_taken) n = ITEM_COUNT - sb.slots_taken;
         stream(n, 1'b0);
      end

      settle();
      repeat (8) @(posedge clock);

      $display("run covered %0d slots and %0d register writes", sb.slots_taken, sb.reg_writes);
      $display("measurements: %0d words read, %0d missing acknowledges, %0d timeouts",
               sb.words_done, sb.ack_fails, sb.timeouts);
      if (sb.errors == 0 && sb.slots_due.size() == 0) begin
         $display("tb_two_wire_humidity_sensor_reader_unit passed");
      end else begin
         $display("tb_two_wire_humidity_sensor_reader_unit failed");
      end
      $finish;
   end

endmodule
